FILE: src/slm_pkg.sv
package slm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int DATA_W     = 32;
  localparam int ACTION_W   = 2;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // action codes on s_tuser
  localparam logic [ACTION_W-1:0] ACT_FIRST  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SECOND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MERGE  = 2'd2;

  // result flag positions on m_tuser
  localparam int USER_SECOND  = 0;
  localparam int USER_EMPTY   = 1;
  localparam int USER_DROPPED = 2;
  localparam int OUT_USER_W   = 3;

  typedef enum logic [1:0] {
    CMD_APPEND_FIRST,
    CMD_APPEND_SECOND,
    CMD_MERGE
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] value;
  } cmd_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PICK
  } back_state_t;

endpackage

FILE: src/slm_ram.sv
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/slm_front.sv
module slm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [slm_pkg::DATA_W-1:0]        s_tdata,  // value
  input  logic [slm_pkg::ACTION_W-1:0]      s_tuser,  // action
  output logic                              q_valid,
  output slm_pkg::cmd_item_t                q_item,
  input  logic                              q_pop
);
  import slm_pkg::*;

  cmd_item_t  q_mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       keep;
  cmd_item_t  item;

  // classify the incoming transaction; unknown actions are swallowed
  always_comb begin
    item.value = s_tdata;
    item.cmd   = CMD_MERGE;
    keep       = 1'b1;
    unique case (s_tuser)
      ACT_FIRST:  item.cmd = CMD_APPEND_FIRST;
      ACT_SECOND: item.cmd = CMD_APPEND_SECOND;
      ACT_MERGE:  item.cmd = CMD_MERGE;
      default:    keep     = 1'b0;
    endcase
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready && keep;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = q_mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: src/slm_back.sv
module slm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  slm_pkg::cmd_item_t            q_item,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [slm_pkg::DATA_W-1:0]    m_tdata,  // value_res
  output logic [slm_pkg::OUT_USER_W-1:0] m_tuser, // from_second, empty_res, dropped
  output logic                          m_tlast
);
  import slm_pkg::*;

  back_state_t state, state_next;
  logic [CNT_W-1:0] first_count, first_count_next;
  logic [CNT_W-1:0] second_count, second_count_next;
  logic overflow_seen, overflow_seen_next;
  logic [CNT_W-1:0] rd_i, rd_i_next;
  logic [CNT_W-1:0] rd_j, rd_j_next;

  logic out_valid, out_valid_next;
  logic [DATA_W-1:0] out_value, out_value_next;
  logic [OUT_USER_W-1:0] out_user, out_user_next;
  logic out_last, out_last_next;

  logic first_we, second_we;
  logic [DATA_W-1:0] first_rdata, second_rdata;

  logic out_free;
  logic first_left, second_left, take_first, is_last;
  logic [CNT_W-1:0] i_adv, j_adv;

  slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_count[ADDR_W-1:0]),
    .wdata (q_item.value),
    .raddr (rd_i[ADDR_W-1:0]),
    .rdata (first_rdata)
  );

  slm_ram #(.WIDTH(DATA_W), .DEPTH(LIST_DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_count[ADDR_W-1:0]),
    .wdata (q_item.value),
    .raddr (rd_j[ADDR_W-1:0]),
    .rdata (second_rdata)
  );

  assign out_free    = !out_valid || m_tready;
  assign first_left  = (rd_i < first_count);
  assign second_left = (rd_j < second_count);
  assign take_first  = first_left &&
                       (!second_left || ($signed(first_rdata) <= $signed(second_rdata)));
  assign i_adv       = rd_i + CNT_W'(take_first);
  assign j_adv       = rd_j + CNT_W'(!take_first);
  assign is_last     = (i_adv == first_count) && (j_adv == second_count);

  always_comb begin
    state_next         = state;
    first_count_next   = first_count;
    second_count_next  = second_count;
    overflow_seen_next = overflow_seen;
    rd_i_next          = rd_i;
    rd_j_next          = rd_j;
    out_valid_next     = out_valid && !m_tready;
    out_value_next     = out_value;
    out_user_next      = out_user;
    out_last_next      = out_last;
    first_we           = 1'b0;
    second_we          = 1'b0;
    q_pop              = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.cmd)
            CMD_APPEND_FIRST: begin
              q_pop = 1'b1;
              if (first_count < CNT_W'(LIST_DEPTH)) begin
                first_we         = 1'b1;
                first_count_next = first_count + CNT_W'(1);
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            CMD_APPEND_SECOND: begin
              q_pop = 1'b1;
              if (second_count < CNT_W'(LIST_DEPTH)) begin
                second_we         = 1'b1;
                second_count_next = second_count + CNT_W'(1);
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            CMD_MERGE: begin
              if (first_count == '0 && second_count == '0) begin
                // empty merge: one marked result
                if (out_free) begin
                  q_pop                        = 1'b1;
                  out_valid_next               = 1'b1;
                  out_value_next               = '0;
                  out_user_next                = '0;
                  out_user_next[USER_EMPTY]    = 1'b1;
                  out_user_next[USER_DROPPED]  = overflow_seen;
                  out_last_next                = 1'b1;
                  overflow_seen_next           = 1'b0;
                end
              end else begin
                q_pop      = 1'b1;
                rd_i_next  = '0;
                rd_j_next  = '0;
                state_next = ST_FETCH;
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_FETCH: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (out_free) begin
          out_valid_next              = 1'b1;
          out_value_next              = take_first ? first_rdata : second_rdata;
          out_user_next               = '0;
          out_user_next[USER_SECOND]  = !take_first;
          out_user_next[USER_DROPPED] = overflow_seen;
          out_last_next               = is_last;
          if (is_last) begin
            first_count_next   = '0;
            second_count_next  = '0;
            overflow_seen_next = 1'b0;
            state_next         = ST_IDLE;
          end else begin
            rd_i_next  = i_adv;
            rd_j_next  = j_adv;
            state_next = ST_FETCH;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      rd_i          <= '0;
      rd_j          <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      first_count   <= first_count_next;
      second_count  <= second_count_next;
      overflow_seen <= overflow_seen_next;
      rd_i          <= rd_i_next;
      rd_j          <= rd_j_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_value <= out_value_next;
    out_user  <= out_user_next;
    out_last  <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_user;
  assign m_tlast  = out_last;

endmodule

FILE: src/sorted_list_merge.sv
// sorted_list_merge: stable merge of two ascending lists of signed 32-bit values
//
// input stream: s_tuser carries the action (0 append to first list, 1 append
// to second list, 2 merge, 3 ignored), s_tdata the value to append.
// output stream: m_tdata is the merged value; m_tuser bit 0 marks a value from
// the second list, bit 1 the single result of an empty merge, bit 2 that an
// append was dropped since the previous merge; m_tlast ends the merge run.
// a two-entry command queue sits between the input side and the executing
// back end, so inputs keep flowing while the back end waits on the output.
// an append leaves the queue and is written to its list ram while the back
// end is idle, so appends can be taken every cycle while it is idle. a merge
// presents its results one by one: each step reads both list rams (registered
// read) and then compares. the back end takes no new command until the merge
// run ends; an empty merge presents its single result straight from the idle
// state.
// reset clears both counts, the drop flag, the queue and the output valid flag;
// list ram contents are not cleared, only written entries are ever read.
// when the receiver stalls the output register holds, the back end waits,
// the queue fills and s_tready drops.
module sorted_list_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [slm_pkg::DATA_W-1:0]     s_tdata,  // value
  input  logic [slm_pkg::ACTION_W-1:0]   s_tuser,  // action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [slm_pkg::DATA_W-1:0]     m_tdata,  // value_res
  output logic [slm_pkg::OUT_USER_W-1:0] m_tuser,  // from_second, empty_res, dropped
  output logic                           m_tlast
);
  import slm_pkg::*;

  logic      q_valid;
  logic      q_pop;
  cmd_item_t q_item;

  slm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  slm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_EMPTY] |-> m_tlast)
    else $error("empty result not marked last");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_EMPTY] |-> m_tdata == '0 && !m_tuser[USER_SECOND])
    else $error("empty result carries data");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

FILE: tb/sorted_list_merge_check.sv
module sorted_list_merge_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [slm_pkg::DATA_W-1:0]     s_tdata,  // value
  input  logic [slm_pkg::ACTION_W-1:0]   s_tuser,  // action
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [slm_pkg::DATA_W-1:0]     m_tdata,  // value_res
  input  logic [slm_pkg::OUT_USER_W-1:0] m_tuser,  // from_second, empty_res, dropped
  input  logic                           m_tlast,
  output int                             fail_count,
  output int                             pending
);
  import slm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     from_second;
    logic                     last;
    logic                     empty;
    logic                     dropped;
  } merged_t;

  logic signed [DATA_W-1:0] first_list  [LIST_DEPTH];
  logic signed [DATA_W-1:0] second_list [LIST_DEPTH];
  int                       first_len;
  int                       second_len;
  logic                     overflow;
  merged_t                  merged_q [$];
  int                       errors;

  initial begin
    errors = 0;
  end

  task automatic add_result(input logic signed [DATA_W-1:0] value, input logic from_second,
                            input logic last, input logic empty);
    merged_t r;
    r.value       = value;
    r.from_second = from_second;
    r.last        = last;
    r.empty       = empty;
    r.dropped     = overflow;
    merged_q.push_back(r);
  endtask

  task automatic apply_action(input logic [ACTION_W-1:0] act,
                              input logic signed [DATA_W-1:0] val);
    int i;
    int j;
    int total;
    i     = 0;
    j     = 0;
    total = first_len + second_len;
    case (act)
      ACT_FIRST: begin
        if (first_len < LIST_DEPTH) begin
          first_list[ADDR_W'(first_len)] = val;
          first_len++;
        end else begin
          overflow = 1'b1;
        end
      end
      ACT_SECOND: begin
        if (second_len < LIST_DEPTH) begin
          second_list[ADDR_W'(second_len)] = val;
          second_len++;
        end else begin
          overflow = 1'b1;
        end
      end
      ACT_MERGE: begin
        if (total == 0) begin
          add_result('0, 1'b0, 1'b1, 1'b1);
        end
        for (int k = 0; k < total; k++) begin
          // ties go to the first list
          if (i < first_len && (j >= second_len ||
              first_list[ADDR_W'(i)] <= second_list[ADDR_W'(j)])) begin
            add_result(first_list[ADDR_W'(i)], 1'b0, k == total - 1, 1'b0);
            i++;
          end else begin
            add_result(second_list[ADDR_W'(j)], 1'b1, k == total - 1, 1'b0);
            j++;
          end
        end
        first_len  = 0;
        second_len = 0;
        overflow   = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_merged();
    merged_t want;
    if (merged_q.size() == 0) begin
      $error("value_res: expected no transaction, got %0h", m_tdata);
      errors++;
    end else begin
      want = merged_q.pop_front();
      check_field("value_res", want.value, m_tdata);
      check_field("from_second", DATA_W'(want.from_second), DATA_W'(m_tuser[USER_SECOND]));
      check_field("last", DATA_W'(want.last), DATA_W'(m_tlast));
      check_field("empty_res", DATA_W'(want.empty), DATA_W'(m_tuser[USER_EMPTY]));
      check_field("dropped", DATA_W'(want.dropped), DATA_W'(m_tuser[USER_DROPPED]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      first_len  = 0;
      second_len = 0;
      overflow   = 1'b0;
      merged_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        apply_action(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        check_merged();
      end
    end
    fail_count <= errors;
    pending    <= merged_q.size();
  end

endmodule

FILE: tb/sorted_list_merge_test.sv
module sorted_list_merge_test;
  import slm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam logic [DATA_W-1:0]   VAL_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0]   VAL_MAX  = 32'h7fff_ffff;
  localparam int RAND_ITEMS = 180;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata = '0;    // value
  logic [ACTION_W-1:0]   s_tuser = '0;    // action
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;         // value_res
  logic [OUT_USER_W-1:0] m_tuser;         // from_second, empty_res, dropped
  logic                  m_tlast;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles = 0;
  int                    loaded = 0;
  bit                    steady = 1'b0;

  sorted_list_merge dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  sorted_list_merge_check check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int list_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 70) return $urandom_range(1, 6);
    if (r < 88) return $urandom_range(7, 31);
    if (r < 94) return LIST_DEPTH;
    return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
  endfunction

  // next value of an ascending run, saturating at the top of the range
  function automatic logic [DATA_W-1:0] ascend(inout longint cur, input bit dense);
    logic [DATA_W-1:0] v;
    int                r;
    v = cur[DATA_W-1:0];
    r = $urandom_range(0, 99);
    if (dense) cur += $urandom_range(0, 3);
    else if (r < 15) cur += 0;
    else if (r < 60) cur += $urandom_range(1, 1000);
    else if (r < 90) cur += $urandom_range(1, 1 << 24);
    else cur += longint'($urandom_range(1, 32'h7fff_ffff));
    if (cur > 64'sd2147483647) cur = 64'sd2147483647;
    return v;
  endfunction

  task automatic send(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    if (act != ACT_NONE) loaded++;
  endtask

  task automatic random_batch();
    int     n1;
    int     n2;
    longint c1;
    longint c2;
    bit     dense;
    bit     noisy;
    steady = ($urandom_range(0, 3) == 0);
    noisy  = ($urandom_range(0, 6) == 0);
    dense  = ($urandom_range(0, 2) == 0);
    n1     = list_size();
    n2     = list_size();
    c1     = longint'($signed($urandom()));
    // a shared start makes ties across the lists likely
    c2     = ($urandom_range(0, 2) == 0) ? c1 : longint'($signed($urandom()));
    while (n1 > 0 || n2 > 0) begin
      if ($urandom_range(0, 19) == 0) send(ACT_NONE, $urandom());
      if (n2 == 0 || (n1 > 0 && $urandom_range(0, 1) == 0)) begin
        send(ACT_FIRST, noisy ? $urandom() : ascend(c1, dense));
        n1--;
      end else begin
        send(ACT_SECOND, noisy ? $urandom() : ascend(c2, dense));
        n2--;
      end
    end
    send(ACT_MERGE, $urandom());
    if ($urandom_range(0, 9) == 0) send(ACT_MERGE, $urandom());
  endtask

  initial begin
    int run;
    int gap;
    repeat (6) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = gap_len();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty merge
    send(ACT_MERGE, 32'h0);
    // extremes with ties across the lists
    send(ACT_FIRST, VAL_MIN);
    send(ACT_FIRST, 32'hffff_ffff);
    send(ACT_FIRST, 32'h0);
    send(ACT_FIRST, 32'd7);
    send(ACT_FIRST, VAL_MAX);
    send(ACT_SECOND, VAL_MIN);
    send(ACT_SECOND, 32'h0);
    send(ACT_SECOND, 32'd7);
    send(ACT_SECOND, 32'd7);
    send(ACT_SECOND, VAL_MAX);
    send(ACT_NONE, 32'hdead_beef);
    send(ACT_MERGE, 32'hffff_ffff);
    // unsorted lists
    send(ACT_FIRST, 32'd9);
    send(ACT_FIRST, 32'd3);
    send(ACT_SECOND, 32'd5);
    send(ACT_MERGE, 32'h0);
    // only the second list
    send(ACT_SECOND, 32'd1);
    send(ACT_MERGE, 32'h0);
    send(ACT_NONE, 32'h5555_aaaa);
    send(ACT_MERGE, 32'h0);

    loaded = 0;
    while (loaded < RAND_ITEMS) random_batch();
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
